@@ rtl/tmrq_pkg.sv @@
// Shared status and mode codes and the bytes per payload word for the tagged message ring queue.
`default_nettype none

package tmrq_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BLOCK   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_RECV = 1'b1;

    localparam int BYTES_PER_WORD = 8;

endpackage

`default_nettype wire

@@ rtl/tagged_message_ring_queue.sv @@
// Message ring queue with per-slot payload, length and sender memories.
//
//   channel | direction | handshake                  | fields
//   --------+-----------+----------------------------+---------------------------------------
//   in      | to block  | i_in_valid / o_in_ready    | mode, payload word, length, sender, last
//   out     | from block| o_out_valid / i_out_ready  | status, is_receive, data, length, sender, last
//
// A send word gives one result. A receive on an empty queue gives one result. A receive
// on a non-empty queue first does the synchronous read of the head slot's metadata and
// first word, then streams one word per cycle.
// The output register stalls the stream while the result is not taken.
// Reset clears the pointers, the count and the send run; the memories are not cleared.
`default_nettype none

module tagged_message_ring_queue
    import tmrq_pkg::*;
#(
    parameter int QUEUE_SLOTS       = 16,
    parameter int WORDS_PER_MESSAGE = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_mode,
    input  wire logic [63:0] i_payload_word,
    input  wire logic [7:0]  i_message_length,
    input  wire logic [15:0] i_sender_id,
    input  wire logic        i_word_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic             o_is_receive,
    output logic [63:0]      o_data_word,
    output logic [7:0]       o_length_out,
    output logic [15:0]      o_sender_out,
    output logic             o_result_last
);

    localparam int SlotW     = $clog2(QUEUE_SLOTS);
    localparam int OccW      = $clog2(QUEUE_SLOTS + 1);
    localparam int CntW      = $clog2(WORDS_PER_MESSAGE + 1);
    localparam int WIdxW     = (WORDS_PER_MESSAGE > 1) ? $clog2(WORDS_PER_MESSAGE) : 1;
    localparam int Depth     = QUEUE_SLOTS * WORDS_PER_MESSAGE;
    localparam int AddrW     = $clog2(Depth);
    localparam int SlotBytes = BYTES_PER_WORD * WORDS_PER_MESSAGE;

    typedef enum logic {S_IDLE, S_STREAM} t_state;
    typedef enum logic [1:0] {RUN_IDLE, RUN_WRITING, RUN_DROP_INVALID, RUN_DROP_FULL} t_run;

    typedef struct packed {
        logic [7:0]      len;
        logic [15:0]     sender;
        logic [CntW-1:0] words;
    } t_meta;

    logic [63:0] r_payload_mem [Depth];
    t_meta       r_meta_mem [QUEUE_SLOTS];
    logic [63:0] r_pay_q;
    t_meta       r_meta_q;

    t_state          r_state, n_state;
    t_run            r_run, n_run;
    logic [SlotW-1:0] r_head, n_head, r_tail, n_tail;
    logic [OccW-1:0] r_occ, n_occ;
    logic [CntW-1:0] r_idx, n_idx;
    logic [CntW-1:0] r_k, n_k;
    logic [7:0]      r_run_len, n_run_len;
    logic [15:0]     r_run_sender, n_run_sender;

    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_status, n_status;
    logic            r_is_receive, n_is_receive;
    logic [63:0]     r_data, n_data;
    logic [7:0]      r_len_out, n_len_out;
    logic [15:0]     r_sender_out, n_sender_out;
    logic            r_last, n_last;

    logic             load_out;
    logic             in_acc;
    logic             pay_we;
    logic [AddrW-1:0] pay_waddr;
    logic [AddrW-1:0] pay_raddr;
    logic             meta_we;
    t_meta            meta_wdata;

    logic [5:0]       s_nwords;
    logic             s_last;
    logic             s_word_ok;
    logic [63:0]      s_data;

    function automatic logic [SlotW-1:0] slot_inc(input logic [SlotW-1:0] s);
        logic [SlotW-1:0] r;
        if (s == SlotW'(QUEUE_SLOTS - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    assign load_out   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && load_out;
    assign in_acc     = i_in_valid && o_in_ready;

    always_comb begin
        logic [8:0] nw;
        logic       partial;
        nw = ({1'b0, r_meta_q.len} + 9'd7) >> 3;
        s_nwords  = (nw == 9'd0) ? 6'd1 : nw[5:0];
        s_last    = (9'(r_k) + 9'd1) == 9'(s_nwords);
        s_word_ok = (9'(r_k) < 9'(r_meta_q.words)) && (r_meta_q.len != 8'd0);
        partial   = s_last && (r_meta_q.len[2:0] != 3'd0);
        for (int b = 0; b < 8; b++) begin
            if (s_word_ok && (!partial || (3'(b) < r_meta_q.len[2:0]))) begin
                s_data[8*b +: 8] = r_pay_q[8*b +: 8];
            end else begin
                s_data[8*b +: 8] = 8'd0;
            end
        end
    end

    always_comb begin
        logic            store_en;
        logic            commit_en;
        logic [CntW-1:0] widx;
        logic [7:0]      c_len;
        logic [15:0]     c_sender;
        store_en     = 1'b0;
        commit_en    = 1'b0;
        widx         = r_idx;
        c_len        = r_run_len;
        c_sender     = r_run_sender;
        n_state      = r_state;
        n_run        = r_run;
        n_head       = r_head;
        n_tail       = r_tail;
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_k          = r_k;
        n_run_len    = r_run_len;
        n_run_sender = r_run_sender;
        n_out_valid  = load_out ? 1'b0 : r_out_valid;
        n_status     = r_status;
        n_is_receive = r_is_receive;
        n_data       = r_data;
        n_len_out    = r_len_out;
        n_sender_out = r_sender_out;
        n_last       = r_last;
        pay_we       = 1'b0;
        pay_waddr    = '0;
        meta_we      = 1'b0;

        if (in_acc && i_mode == MODE_SEND) begin
            n_out_valid  = 1'b1;
            n_status     = ST_OK;
            n_is_receive = 1'b0;
            n_data       = '0;
            n_len_out    = '0;
            n_sender_out = '0;
            n_last       = 1'b1;
            case (r_run)
                RUN_IDLE: begin
                    if ({1'b0, i_message_length} > 9'(SlotBytes)) begin
                        n_status = ST_INVALID;
                        n_run    = i_word_last ? RUN_IDLE : RUN_DROP_INVALID;
                    end else if (r_occ == OccW'(QUEUE_SLOTS)) begin
                        n_status = ST_BLOCK;
                        n_run    = i_word_last ? RUN_IDLE : RUN_DROP_FULL;
                    end else begin
                        n_run_len    = i_message_length;
                        n_run_sender = i_sender_id;
                        c_len        = i_message_length;
                        c_sender     = i_sender_id;
                        store_en     = 1'b1;
                        widx         = '0;
                        commit_en    = i_word_last;
                        n_run        = RUN_WRITING;
                    end
                end
                RUN_WRITING: begin
                    store_en  = r_idx < CntW'(WORDS_PER_MESSAGE);
                    commit_en = i_word_last;
                end
                default: begin
                    n_status = (r_run == RUN_DROP_INVALID) ? ST_INVALID : ST_BLOCK;
                    if (i_word_last) begin
                        n_run = RUN_IDLE;
                    end
                end
            endcase
            if (store_en) begin
                pay_we    = 1'b1;
                pay_waddr = AddrW'(r_tail) * AddrW'(WORDS_PER_MESSAGE) + AddrW'(widx[WIdxW-1:0]);
                widx      = widx + 1'b1;
            end
            if (r_run == RUN_IDLE || r_run == RUN_WRITING) begin
                n_idx = widx;
            end
            if (commit_en) begin
                meta_we = 1'b1;
                n_tail  = slot_inc(r_tail);
                n_occ   = r_occ + 1'b1;
                n_idx   = '0;
                n_run   = RUN_IDLE;
            end
        end else if (in_acc && i_mode == MODE_RECV) begin
            if (r_occ == '0) begin
                n_out_valid  = 1'b1;
                n_status     = ST_BLOCK;
                n_is_receive = 1'b1;
                n_data       = '0;
                n_len_out    = '0;
                n_sender_out = '0;
                n_last       = 1'b1;
            end else begin
                n_state = S_STREAM;
                n_k     = '0;
            end
        end

        if (r_state == S_STREAM && load_out) begin
            n_out_valid  = 1'b1;
            n_status     = ST_OK;
            n_is_receive = 1'b1;
            n_data       = s_data;
            n_len_out    = r_meta_q.len;
            n_sender_out = r_meta_q.sender;
            n_last       = s_last;
            if (s_last) begin
                n_state = S_IDLE;
                n_head  = slot_inc(r_head);
                n_occ   = r_occ - 1'b1;
                n_k     = '0;
            end else begin
                n_k = r_k + 1'b1;
            end
        end

        meta_wdata.len    = c_len;
        meta_wdata.sender = c_sender;
        meta_wdata.words  = widx;
        pay_raddr = AddrW'(n_head) * AddrW'(WORDS_PER_MESSAGE) + AddrW'(n_k[WIdxW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            r_payload_mem[pay_waddr] <= i_payload_word;
        end
        r_pay_q <= r_payload_mem[pay_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[r_tail] <= meta_wdata;
        end
        r_meta_q <= r_meta_mem[n_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= RUN_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_idx       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_run        <= n_run;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_occ        <= n_occ;
            r_idx        <= n_idx;
            r_k          <= n_k;
            r_out_valid  <= n_out_valid;
            r_run_len    <= n_run_len;
            r_run_sender <= n_run_sender;
            r_status     <= n_status;
            r_is_receive <= n_is_receive;
            r_data       <= n_data;
            r_len_out    <= n_len_out;
            r_sender_out <= n_sender_out;
            r_last       <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_is_receive  = r_is_receive;
    assign o_data_word   = r_data;
    assign o_length_out  = r_len_out;
    assign o_sender_out  = r_sender_out;
    assign o_result_last = r_last;

endmodule

`default_nettype wire
